@@ hdl/cpv_pkg.sv @@
// Shared types, constants and the CRC byte function for the calibration
// profile validator. No dependencies.
`default_nettype none

package cpv_pkg;

  localparam int unsigned LimitW = 15;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // byte_index value that means no profile in progress
  localparam logic [IdxW-1:0] IdleIndex = 5'd22;
  localparam logic [IdxW-1:0] LastIndex = 5'd21;

  // field numbers (byte_index >> 1) that change limit group
  localparam logic [3:0] FieldMagFirst   = 4'd3;
  localparam logic [3:0] FieldGyroFirst  = 4'd6;
  localparam logic [3:0] FieldAccelRad   = 4'd9;

  // verdict codes
  localparam logic [1:0] VerdictOk       = 2'd0;
  localparam logic [1:0] VerdictCrcFail  = 2'd1;
  localparam logic [1:0] VerdictRangeFail = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegAccelOffset = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMagOffset   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGyroOffset  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAccelRadius = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMagRadius   = 3'd4;

  // limit reset values
  localparam logic [LimitW-1:0] AccelOffsetRst = 15'd16000;
  localparam logic [LimitW-1:0] MagOffsetRst   = 15'd6400;
  localparam logic [LimitW-1:0] GyroOffsetRst  = 15'd32000;
  localparam logic [LimitW-1:0] AccelRadiusRst = 15'd1000;
  localparam logic [LimitW-1:0] MagRadiusRst   = 15'd960;

  typedef struct packed {
    logic [LimitW-1:0] accel_offset;
    logic [LimitW-1:0] mag_offset;
    logic [LimitW-1:0] gyro_offset;
    logic [LimitW-1:0] accel_radius;
    logic [LimitW-1:0] mag_radius;
  } limits_t;

  // item as held in the input register; seed is the CRC over the install ID
  typedef struct packed {
    logic [7:0]  pbyte;
    logic        start;
    logic [15:0] seed;
    logic [15:0] exp_crc;
  } item_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cpv_cfg.sv @@
// Limit registers of the calibration profile validator.
// Depends on cpv_pkg.
`default_nettype none

module cpv_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [cpv_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [cpv_pkg::LimitW-1:0]  cfg_data,
  output cpv_pkg::limits_t                limits
);
  import cpv_pkg::*;

  limits_t lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.accel_offset <= AccelOffsetRst;
      lim.mag_offset   <= MagOffsetRst;
      lim.gyro_offset  <= GyroOffsetRst;
      lim.accel_radius <= AccelRadiusRst;
      lim.mag_radius   <= MagRadiusRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegAccelOffset: lim.accel_offset <= cfg_data;
        RegMagOffset:   lim.mag_offset   <= cfg_data;
        RegGyroOffset:  lim.gyro_offset  <= cfg_data;
        RegAccelRadius: lim.accel_radius <= cfg_data;
        RegMagRadius:   lim.mag_radius   <= cfg_data;
        default: ; // unmapped index: ignored
      endcase
    end
  end

  assign limits = lim;

endmodule

`default_nettype wire

@@ hdl/cpv_in_stage.sv @@
// Input register of the validator; pre-computes the install ID CRC seed.
// Depends on cpv_pkg.
`default_nettype none

module cpv_in_stage (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  profile_byte,
  input  wire logic        start_req,
  input  wire logic [15:0] install_id,
  input  wire logic [15:0] expected_crc,
  input  wire logic        take,
  output logic             item_valid,
  output cpv_pkg::item_t   item
);
  import cpv_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  accept;

  assign in_ready = !valid_q || take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.pbyte   <= profile_byte;
      item_q.start   <= start_req;
      item_q.seed    <= crc_byte(crc_byte(CrcInit, install_id[7:0]), install_id[15:8]);
      item_q.exp_crc <= expected_crc;
    end
  end

  assign item_valid = valid_q;
  assign item       = item_q;

endmodule

`default_nettype wire

@@ hdl/cpv_engine.sv @@
// Profile state, CRC update, field range check and result register.
// Depends on cpv_pkg.
`default_nettype none

module cpv_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire cpv_pkg::item_t   item,
  input  wire cpv_pkg::limits_t limits,
  output logic                  take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [15:0]           computed_crc,
  output logic                  crc_match,
  output logic                  in_range,
  output logic [1:0]            verdict
);
  import cpv_pkg::*;

  logic [15:0]     crc_reg;
  logic [IdxW-1:0] byte_index;
  logic [7:0]      low_byte_latch;
  logic            range_fail;
  logic [15:0]     expected_crc_latch;

  logic            out_valid_q;
  logic [15:0]     crc_out;
  logic            match_out;
  logic            range_out;
  logic [1:0]      verdict_out;

  logic            active;
  logic [IdxW-1:0] idx;
  logic [15:0]     crc_next;
  logic [15:0]     exp_eff;
  logic            fail_base;
  logic            fail_next;
  logic            last;
  logic [3:0]      field;
  logic [LimitW-1:0] lim;
  logic signed [16:0] val;
  logic signed [16:0] lim_pos;
  logic signed [16:0] lim_neg;
  logic            field_bad;
  logic            match_now;

  assign take = item_valid && (!out_valid_q || out_ready);

  always_comb begin
    active    = item.start || (byte_index != IdleIndex);
    idx       = item.start ? '0 : byte_index;
    crc_next  = crc_byte(item.start ? item.seed : crc_reg, item.pbyte);
    exp_eff   = item.start ? item.exp_crc : expected_crc_latch;
    fail_base = item.start ? 1'b0 : range_fail;
    last      = (idx == LastIndex);
    field     = idx[IdxW-1:1];

    priority if (field < FieldMagFirst) begin
      lim = limits.accel_offset;
    end else if (field < FieldGyroFirst) begin
      lim = limits.mag_offset;
    end else if (field < FieldAccelRad) begin
      lim = limits.gyro_offset;
    end else if (field == FieldAccelRad) begin
      lim = limits.accel_radius;
    end else begin
      lim = limits.mag_radius;
    end

    // low byte comes from the latch; odd offsets never carry a start
    val       = $signed({item.pbyte[7], item.pbyte, low_byte_latch});
    lim_pos   = $signed({2'b00, lim});
    lim_neg   = -lim_pos;
    field_bad = (val > lim_pos) || (val < lim_neg);
    fail_next = fail_base || (idx[0] && field_bad);
    match_now = (crc_next == exp_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg            <= CrcInit;
      byte_index         <= IdleIndex;
      low_byte_latch     <= '0;
      range_fail         <= 1'b0;
      expected_crc_latch <= '0;
    end else if (take && active) begin
      crc_reg            <= crc_next;
      expected_crc_latch <= exp_eff;
      range_fail         <= fail_next;
      if (!idx[0]) begin
        low_byte_latch <= item.pbyte;
      end
      byte_index <= last ? IdleIndex : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (take && active && last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && active && last) begin
      crc_out   <= crc_next;
      match_out <= match_now;
      range_out <= !fail_next;
      if (!match_now) begin
        verdict_out <= VerdictCrcFail;
      end else if (fail_next) begin
        verdict_out <= VerdictRangeFail;
      end else begin
        verdict_out <= VerdictOk;
      end
    end
  end

  assign out_valid    = out_valid_q;
  assign computed_crc = crc_out;
  assign crc_match    = match_out;
  assign in_range     = range_out;
  assign verdict      = verdict_out;

endmodule

`default_nettype wire

@@ hdl/calibration_profile_validator_unit.sv @@
// Top level of the calibration profile validator.
// Depends on cpv_pkg, cpv_cfg, cpv_in_stage and cpv_engine.
//
// Use:
//   Profile bytes enter one item per cycle on the in_* channel (valid/ready).
//   An item with start_req set is offset 0 of a new profile; install_id and
//   expected_crc are sampled with it. Bytes arriving with no profile open are
//   dropped. After offset 21 one result item leaves on the out_* channel:
//   computed_crc, crc_match, in_range and verdict (CRC mismatch outranks a
//   range failure).
//   Limits are written through cfg_we/cfg_index/cfg_data, one register per
//   cycle, while no profile is in flight; unmapped indexes are ignored.
// Timing:
//   Throughput is one item per cycle while no result stalls. Each item
//   passes an input register (where the install ID CRC seed is formed)
//   and then the engine, which updates the CRC by one byte and range-checks
//   a completed field in the same cycle. The last byte's result is held in
//   the engine's result register, which drives the out port.
// Reset (rst, synchronous): limits return to their defaults, no profile is
//   open, both registers are empty.
// Stall: while a result waits for out_ready the engine holds, the input
//   register still takes one more item if it is empty, then in_ready falls.
`default_nettype none

module calibration_profile_validator_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input item channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  profile_byte,
  input  wire logic                        start_req,
  input  wire logic [15:0]                 install_id,
  input  wire logic [15:0]                 expected_crc,
  // result item channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [15:0]                      computed_crc,
  output logic                             crc_match,
  output logic                             in_range,
  output logic [1:0]                       verdict,
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic [cpv_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [cpv_pkg::LimitW-1:0]  cfg_data
);
  import cpv_pkg::*;

  limits_t limits;
  item_t   item;
  logic    item_valid;
  logic    take;

  // limit registers
  cpv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  // input register, doubles as skid stage while the result stalls
  cpv_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .profile_byte (profile_byte),
    .start_req    (start_req),
    .install_id   (install_id),
    .expected_crc (expected_crc),
    .take         (take),
    .item_valid   (item_valid),
    .item         (item)
  );

  // CRC, range check and result register
  cpv_engine u_eng (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .limits       (limits),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .computed_crc (computed_crc),
    .crc_match    (crc_match),
    .in_range     (in_range),
    .verdict      (verdict)
  );

endmodule

`default_nettype wire

@@ hdl/cpv_checker.sv @@
// Port-level checks for the calibration profile validator, bound to the top.
// Depends on cpv_pkg and calibration_profile_validator_unit.
`default_nettype none

module cpv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] computed_crc,
  input wire logic        crc_match,
  input wire logic        in_range,
  input wire logic [1:0]  verdict
);
  import cpv_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(computed_crc)
      && $stable(verdict) && $stable(crc_match) && $stable(in_range))
    else $error("result item changed while stalled");

  // CRC mismatch always gives the CRC verdict
  a_crc_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && !crc_match |-> verdict == VerdictCrcFail)
    else $error("CRC mismatch without CRC verdict");

  // with a good CRC the verdict follows the range flag
  a_range_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && crc_match |->
      ((in_range && verdict == VerdictOk) || (!in_range && verdict == VerdictRangeFail)))
    else $error("verdict disagrees with CRC and range flags");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind calibration_profile_validator_unit cpv_checker u_cpv_checker (.*);

`default_nettype wire
